// ===== design/rms_pkg.sv =====
// Package for the ringtone melody sequencer: field widths, item kind codes,
// note ROM contents and the volume-to-duty mapping. No dependencies.
`default_nettype none

package rms_pkg;

    localparam int ROM_ROWS = 4;
    localparam int ROM_COLS = 6;
    localparam int ROW_W    = 2;
    localparam int COL_W    = 3;
    localparam int HZ_W     = 10;
    localparam int MS_W     = 11;
    localparam int VOL_W    = 7;
    localparam int DUTY_W   = 8;
    localparam int KIND_W   = 2;
    localparam int RT_W     = 3;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_START = 2'd1,
        KIND_STOP  = 2'd2
    } kind_t;

    localparam logic REG_VOLUME = 1'b0;
    localparam logic REG_OUTPUT = 1'b1;

    localparam logic [VOL_W-1:0] VOL_MIN = 7'd1;
    localparam logic [VOL_W-1:0] VOL_MAX = 7'd100;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } rom_addr_t;

    typedef struct packed {
        logic [HZ_W-1:0] hz;
        logic [MS_W-1:0] ms;
    } note_t;

    localparam logic [HZ_W-1:0] ROM_HZ [ROM_ROWS][ROM_COLS] = '{
        '{10'd523, 10'd0, 10'd659, 10'd0, 10'd0,   10'd0},
        '{10'd440, 10'd0, 10'd523, 10'd0, 10'd0,   10'd0},
        '{10'd392, 10'd0, 10'd440, 10'd0, 10'd523, 10'd0},
        '{10'd494, 10'd0, 10'd587, 10'd0, 10'd494, 10'd0}
    };

    localparam logic [MS_W-1:0] ROM_MS [ROM_ROWS][ROM_COLS] = '{
        '{11'd140, 11'd120, 11'd240, 11'd1400, 11'd0,   11'd0},
        '{11'd180, 11'd160, 11'd260, 11'd1200, 11'd0,   11'd0},
        '{11'd160, 11'd90,  11'd160, 11'd90,   11'd280, 11'd1100},
        '{11'd170, 11'd120, 11'd170, 11'd120,  11'd170, 11'd900}
    };

    localparam logic [COL_W-1:0] ROM_LEN [ROM_ROWS] = '{3'd4, 3'd4, 3'd6, 3'd6};

    function automatic note_t note_lookup(input rom_addr_t addr);
        note_t n;
        n = '0;
        if (addr.col < COL_W'(ROM_COLS))
        begin
            n.hz = ROM_HZ[addr.row][addr.col];
            n.ms = ROM_MS[addr.row][addr.col];
        end
        return n;
    endfunction

    function automatic logic [VOL_W-1:0] vol_sat(input logic [VOL_W-1:0] v);
        logic [VOL_W-1:0] r;
        r = v;
        if (v < VOL_MIN)
            r = VOL_MIN;
        else if (v > VOL_MAX)
            r = VOL_MAX;
        return r;
    endfunction

    // pct = 1 + (vol-1)*9/99 steps up at vol = 11k+1
    function automatic logic [DUTY_W-1:0] duty_of(input logic [VOL_W-1:0] vol);
        logic [3:0] pct;
        logic [DUTY_W-1:0] d;
        pct = 4'd1;
        for (int k = 1; k <= 9; k++)
        begin
            if (vol >= VOL_W'(11 * k + 1))
                pct = pct + 4'd1;
        end
        case (pct)
            4'd1:    d = 8'd2;
            4'd2:    d = 8'd5;
            4'd3:    d = 8'd7;
            4'd4:    d = 8'd10;
            4'd5:    d = 8'd12;
            4'd6:    d = 8'd15;
            4'd7:    d = 8'd17;
            4'd8:    d = 8'd20;
            4'd9:    d = 8'd22;
            4'd10:   d = 8'd25;
            default: d = 8'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== design/rms_note_rom.sv =====
// Note ROM with two synchronous read ports and registered outputs.
// Depends on rms_pkg for the table contents and address/data types.
`default_nettype none

module rms_note_rom
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire rms_pkg::rom_addr_t addr_a,
    input  wire rms_pkg::rom_addr_t addr_b,
    output rms_pkg::note_t         note_a,
    output rms_pkg::note_t         note_b
);

    rms_pkg::note_t note_a_reg;
    rms_pkg::note_t note_b_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            note_a_reg <= rms_pkg::note_lookup(addr_a);
            note_b_reg <= rms_pkg::note_lookup(addr_b);
        end
    end

    assign note_a = note_a_reg;
    assign note_b = note_b_reg;

endmodule

`default_nettype wire

// ===== design/ringtone_melody_sequencer_core.sv =====
// Ringtone melody sequencer top level: item handshake, player state, output word.
// Depends on rms_pkg and rms_note_rom.
//
// Sustains one item per clock while no output stall holds the update stage. An
// accepted word reads the note ROM (current note on one port, the note it may
// move to on the other) in the accept cycle; the update stage then updates the
// player state and loads the output register. The updated state is forwarded to
// the ROM address of the following item. The output register decouples the
// sides: input is taken while a result waits, and stalls only when the update
// stage is held by a full output. Config writes are always accepted.
`default_nettype none

module ringtone_melody_sequencer_core
#(
    parameter int MELODY_COUNT = 4,
    parameter int MAX_NOTES    = 6,
    parameter int TIMER_BITS   = 11
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output      logic                               s_tready,
    input  wire logic [rms_pkg::IN_TDATA_W-1:0]     s_tdata,   // [2:0] ringtone
    input  wire logic [rms_pkg::KIND_W-1:0]         s_tuser,   // [1:0] kind
    output      logic                               m_tvalid,
    input  wire logic                               m_tready,
    // [9:0] tone_hz, [17:10] duty, [18] playing, [19] note_started
    output      logic [rms_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  wire logic                               cfg_valid,
    output      logic                               cfg_ready,
    input  wire logic                               cfg_index,
    input  wire logic [rms_pkg::VOL_W-1:0]          cfg_data
);

    localparam int MELODY_ROWS = (MELODY_COUNT < rms_pkg::ROM_ROWS) ?
                                 MELODY_COUNT : rms_pkg::ROM_ROWS;
    localparam int TW = (TIMER_BITS > rms_pkg::MS_W) ? TIMER_BITS : rms_pkg::MS_W;
    localparam logic [TW-1:0] TMAX_W = TW'((1 << TIMER_BITS) - 1);
    localparam logic [4:0] MAX_NOTES_L = 5'(MAX_NOTES);

    // configuration
    logic [rms_pkg::DUTY_W-1:0] duty_reg;
    logic                       present_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg    <= rms_pkg::duty_of(rms_pkg::VOL_MIN);
            present_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == rms_pkg::REG_VOLUME)
                duty_reg <= rms_pkg::duty_of(rms_pkg::vol_sat(cfg_data));
            else
                present_reg <= cfg_data[0];
        end
    end

    // player state
    logic                        active_reg, active_next;
    logic [rms_pkg::ROW_W-1:0]   sel_reg, sel_next, sel_fwd;
    logic [rms_pkg::COL_W-1:0]   pos_reg, pos_next, pos_fwd;
    logic [TIMER_BITS-1:0]       el_reg, el_next;

    // update stage
    logic                        s1_valid_reg;
    logic [rms_pkg::KIND_W-1:0]  s1_kind_reg;
    logic [rms_pkg::ROW_W-1:0]   s1_start_row_reg;
    logic [rms_pkg::COL_W-1:0]   s1_next_col_reg;
    logic                        s1_fire;
    logic                        in_fire;

    // output word
    logic                               out_valid_reg;
    logic [rms_pkg::OUT_TDATA_W-1:0]    out_data_reg, out_data_next;

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // accept side: ROM addresses from forwarded state
    logic [rms_pkg::ROW_W-1:0] start_row;
    logic [rms_pkg::COL_W-1:0] next_col;
    logic [4:0]                len_fwd;
    logic [4:0]                pos_inc;
    rms_pkg::rom_addr_t        addr_a, addr_b;
    rms_pkg::note_t            note_a, note_b;

    assign sel_fwd = s1_fire ? sel_next : sel_reg;
    assign pos_fwd = s1_fire ? pos_next : pos_reg;

    always_comb
    begin
        start_row = '0;
        if ({1'b0, s_tdata[rms_pkg::RT_W-1:0]} < 4'(MELODY_ROWS))
            start_row = s_tdata[rms_pkg::ROW_W-1:0];
        len_fwd = {2'b00, rms_pkg::ROM_LEN[sel_fwd]};
        if (len_fwd > MAX_NOTES_L)
            len_fwd = MAX_NOTES_L;
        pos_inc  = {2'b00, pos_fwd} + 5'd1;
        next_col = (pos_inc >= len_fwd) ? '0 : pos_inc[rms_pkg::COL_W-1:0];
        addr_a.row = sel_fwd;
        addr_a.col = pos_fwd;
        if (s_tuser == rms_pkg::KIND_START)
        begin
            addr_b.row = start_row;
            addr_b.col = '0;
        end
        else
        begin
            addr_b.row = sel_fwd;
            addr_b.col = next_col;
        end
    end

    rms_note_rom u_rom
    (
        .clk    (clk),
        .en     (in_fire),
        .addr_a (addr_a),
        .addr_b (addr_b),
        .note_a (note_a),
        .note_b (note_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= 1'b1;
        else if (s1_fire)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_kind_reg      <= s_tuser;
            s1_start_row_reg <= start_row;
            s1_next_col_reg  <= next_col;
        end
    end

    // update stage logic
    logic [TW-1:0]             dur_w;
    logic [TIMER_BITS-1:0]     el_inc;
    logic                      started;
    logic                      use_b;
    logic [rms_pkg::HZ_W-1:0]  hz;
    logic [rms_pkg::DUTY_W-1:0] duty;

    always_comb
    begin
        active_next = active_reg;
        sel_next    = sel_reg;
        pos_next    = pos_reg;
        el_next     = el_reg;
        started     = 1'b0;
        use_b       = 1'b0;
        dur_w = TW'(note_a.ms);
        if (dur_w > TMAX_W)
            dur_w = TMAX_W;
        el_inc = (el_reg != '1) ? el_reg + 1'b1 : el_reg;
        case (s1_kind_reg)
            rms_pkg::KIND_START:
            begin
                if (present_reg)
                begin
                    active_next = 1'b1;
                    sel_next    = s1_start_row_reg;
                    pos_next    = '0;
                    el_next     = '0;
                    started     = 1'b1;
                    use_b       = 1'b1;
                end
            end
            rms_pkg::KIND_STOP:
            begin
                active_next = 1'b0;
                pos_next    = '0;
                el_next     = '0;
            end
            rms_pkg::KIND_TICK:
            begin
                if (active_reg && present_reg)
                begin
                    el_next = el_inc;
                    if (TW'(el_inc) >= dur_w)
                    begin
                        pos_next = s1_next_col_reg;
                        el_next  = '0;
                        started  = 1'b1;
                        use_b    = 1'b1;
                    end
                end
            end
            default:
            begin
                active_next = active_reg;
            end
        endcase
        hz = '0;
        if (active_next && present_reg)
            hz = use_b ? note_b.hz : note_a.hz;
        duty = (hz != '0) ? duty_reg : '0;
        out_data_next = {4'b0000, started, active_next, duty, hz};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            sel_reg    <= '0;
            pos_reg    <= '0;
            el_reg     <= '0;
        end
        else if (s1_fire)
        begin
            active_reg <= active_next;
            sel_reg    <= sel_next;
            pos_reg    <= pos_next;
            el_reg     <= el_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
            out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// ===== design/rms_checker.sv =====
// Port-level checks on the output words of the ringtone melody sequencer,
// attached to the top level by the bind at the end. Depends on rms_pkg.
`default_nettype none

module rms_checker
(
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [rms_pkg::OUT_TDATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word dropped or changed while stalled");

    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[18] |-> m_tdata[9:0] == 10'd0 && m_tdata[17:10] == 8'd0)
        else $error("sound while not playing");

    a_rest_no_duty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[9:0] == 10'd0 |-> m_tdata[17:10] == 8'd0)
        else $error("nonzero duty on a rest");

    a_start_playing: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[19] |-> m_tdata[18])
        else $error("note started while idle");

endmodule

bind ringtone_melody_sequencer_core rms_checker u_rms_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
